@@ rtl/core/afb_pkg.sv @@
// afb_pkg: shared types and constants for the audio fifo bank
// item kinds, sequencer states, register offsets and the sample store port
// no dependencies
`timescale 1ns / 1ps

package afb_pkg;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_FRAME = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUS,
        ST_TICK,
        ST_MIX,
        ST_MIX_WAIT,
        ST_RESP
    } t_state;

    localparam logic [7:0] OFS_PUSH_LAST  = 8'h0E;
    localparam logic [7:0] OFS_LEVEL_BASE = 8'h10;
    localparam logic [7:0] OFS_STATUS     = 8'h18;
    localparam logic [7:0] OFS_CLEAR      = 8'h1A;
    localparam logic [7:0] OFS_THRESHOLD  = 8'h1C;
    localparam logic [7:0] OFS_ENABLE     = 8'h1E;

    localparam logic [7:0] THRESHOLD_RST = 8'd128;

    localparam int CH_W       = 3;
    localparam int PTR_W      = 8;
    localparam int STORE_AW   = CH_W + PTR_W;
    localparam int STORE_DW   = 8;
    localparam int SUM_W      = 11;
    localparam int MIX_W      = 16;
    localparam int MIX_SHIFT  = MIX_W - SUM_W;

    typedef struct packed {
        logic                wr_en;
        logic [STORE_AW-1:0] wr_addr;
        logic [STORE_DW-1:0] wr_data;
        logic                rd_en;
        logic [STORE_AW-1:0] rd_addr;
    } t_store_req;

endpackage

@@ rtl/core/afb_if.sv @@
// afb_in_if / afb_out_if: valid-ready channels for items and results
// uses afb_pkg for field widths
`timescale 1ns / 1ps

interface afb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] offset;
    logic [7:0] write_data;

    modport source (output valid, output kind, output offset, output write_data, input ready);
    modport sink   (input valid, input kind, input offset, input write_data, output ready);
endinterface

interface afb_out_if;
    logic                             valid;
    logic                             ready;
    logic [7:0]                       read_data;
    logic                             irq;
    logic signed [afb_pkg::MIX_W-1:0] mix_left;
    logic signed [afb_pkg::MIX_W-1:0] mix_right;

    modport source (output valid, output read_data, output irq, output mix_left,
                    output mix_right, input ready);
    modport sink   (input valid, input read_data, input irq, input mix_left,
                    input mix_right, output ready);
endinterface

@@ rtl/core/afb_store.sv @@
// afb_store: sample byte store, one write and one read port, registered read
// uses afb_pkg for the port struct and widths
`timescale 1ns / 1ps

module afb_store (
    input  logic                                i_clk,
    input  afb_pkg::t_store_req                 i_req,
    output logic [afb_pkg::STORE_DW-1:0]        o_rd_data
);

    logic [afb_pkg::STORE_DW-1:0] mem [2**afb_pkg::STORE_AW];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd_data <= mem[i_req.rd_addr];
        end
    end

endmodule

@@ rtl/core/audio_fifo_bank_with_threshold_irq.sv @@
// audio_fifo_bank_with_threshold_irq: eight sample fifos behind byte registers
// steps: a bus read or write goes through ST_BUS, a tick sweeps every channel in
// ST_TICK (straight to ST_RESP when disabled), a frame does one store read per
// channel in ST_MIX and then passes ST_MIX_WAIT; every item ends in ST_RESP
// one item at a time, next beat taken once the result is registered
// reset: synchronous, levels, pointers and status zero, threshold 128, enable on, store kept
`timescale 1ns / 1ps

module audio_fifo_bank_with_threshold_irq #(
    parameter int FIFO_DEPTH = 255,
    parameter int CHANNELS   = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    afb_in_if.sink         i_in,
    afb_out_if.source      o_out
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [afb_pkg::CH_W-1:0] LAST_CH = afb_pkg::CH_W'(CHANNELS - 1);
    localparam logic [7:0] DEPTH_MAX = 8'(FIFO_DEPTH);

    afb_pkg::t_state r_state, n_state;

    logic [1:0]                   r_kind;
    logic [7:0]                   r_offset;
    logic [7:0]                   r_wdata;
    logic [afb_pkg::CH_W-1:0]     r_ch;
    logic [7:0]                   r_rp  [CHANNELS];
    logic [7:0]                   r_lvl [CHANNELS];
    logic [7:0]                   r_status, n_status;
    logic [7:0]                   r_thr, n_thr;
    logic                         r_en, n_en;
    logic [7:0]                   r_rd, n_rd;
    logic signed [afb_pkg::SUM_W-1:0] r_sum;
    logic                         r_acc, n_acc;

    logic                         r_out_valid;
    logic [7:0]                   r_out_rd;
    logic                         r_out_irq;
    logic signed [afb_pkg::MIX_W-1:0] r_out_mix;

    logic [afb_pkg::CH_W-1:0]     w_ch;
    logic                         w_ch_ok;
    logic [CW-1:0]                w_idx;
    logic [7:0]                   w_lvl, w_rp, n_lvl, n_rp;
    logic                         w_lvl_we, w_rp_we;
    logic                         w_accept, w_out_free, w_load_out;
    afb_pkg::t_store_req          w_req;
    logic [afb_pkg::STORE_DW-1:0] w_mem_q;

    afb_store u_store (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_data (w_mem_q)
    );

    // one channel is looked at per cycle: the bus target or the sweep counter
    always_comb begin
        if (r_state == afb_pkg::ST_BUS) begin
            w_ch = (r_kind == afb_pkg::KIND_READ) ? r_offset[2:0] : r_offset[3:1];
        end else begin
            w_ch = r_ch;
        end
    end

    assign w_ch_ok = ({1'b0, w_ch} < 4'(CHANNELS));
    assign w_idx   = w_ch_ok ? w_ch[CW-1:0] : '0;
    assign w_lvl   = r_lvl[w_idx];
    assign w_rp    = r_rp[w_idx];

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        w_req      = '0;
        w_lvl_we   = 1'b0;
        w_rp_we    = 1'b0;
        n_lvl      = w_lvl;
        n_rp       = w_rp;
        n_status   = r_status;
        n_thr      = r_thr;
        n_en       = r_en;
        n_rd       = r_rd;
        n_acc      = 1'b0;
        w_load_out = 1'b0;

        unique case (r_state)
            afb_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                n_rd       = '0;
                if (i_in.valid) begin
                    case (i_in.kind)
                        afb_pkg::KIND_TICK:  n_state = r_en ? afb_pkg::ST_TICK
                                                            : afb_pkg::ST_RESP;
                        afb_pkg::KIND_FRAME: n_state = afb_pkg::ST_MIX;
                        default:             n_state = afb_pkg::ST_BUS;
                    endcase
                end
            end

            afb_pkg::ST_BUS: begin
                if (r_kind == afb_pkg::KIND_READ) begin
                    if (r_offset[7:3] == afb_pkg::OFS_LEVEL_BASE[7:3]) begin
                        n_rd = w_ch_ok ? w_lvl : '0;
                    end else if (r_offset == afb_pkg::OFS_STATUS) begin
                        n_rd = r_status;
                    end else if (r_offset == afb_pkg::OFS_THRESHOLD) begin
                        n_rd = r_thr;
                    end
                end else begin
                    if (r_offset <= afb_pkg::OFS_PUSH_LAST) begin
                        // full fifo drops the sample
                        if (!r_offset[0] && w_ch_ok && (w_lvl < DEPTH_MAX)) begin
                            w_req.wr_en   = 1'b1;
                            w_req.wr_addr = {w_ch, 8'(w_rp + w_lvl)};
                            w_req.wr_data = r_wdata;
                            w_lvl_we      = 1'b1;
                            n_lvl         = w_lvl + 8'd1;
                        end
                    end else if (r_offset == afb_pkg::OFS_CLEAR) begin
                        n_status = r_status & ~r_wdata;
                    end else if (r_offset == afb_pkg::OFS_THRESHOLD) begin
                        n_thr = r_wdata;
                    end else if (r_offset == afb_pkg::OFS_ENABLE) begin
                        n_en = r_wdata[0];
                    end
                end
                n_state = afb_pkg::ST_RESP;
            end

            afb_pkg::ST_TICK: begin
                if (w_lvl != 8'd0) begin
                    w_lvl_we = 1'b1;
                    w_rp_we  = 1'b1;
                    n_lvl    = w_lvl - 8'd1;
                    n_rp     = w_rp + 8'd1;
                    if ((w_lvl - 8'd1) < r_thr) begin
                        n_status = r_status | (8'd1 << w_ch);
                    end
                end
                if (r_ch == LAST_CH) begin
                    n_state = afb_pkg::ST_RESP;
                end
            end

            afb_pkg::ST_MIX: begin
                w_req.rd_en   = 1'b1;
                w_req.rd_addr = {w_ch, w_rp};
                n_acc         = (w_lvl != 8'd0);
                if (r_ch == LAST_CH) begin
                    n_state = afb_pkg::ST_MIX_WAIT;
                end
            end

            afb_pkg::ST_MIX_WAIT: begin
                n_state = afb_pkg::ST_RESP;
            end

            afb_pkg::ST_RESP: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = afb_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = afb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= afb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_rp[i]  <= '0;
                r_lvl[i] <= '0;
            end
            r_status <= '0;
            r_thr    <= afb_pkg::THRESHOLD_RST;
            r_en     <= 1'b1;
            r_ch     <= '0;
            r_acc    <= 1'b0;
        end else begin
            if (w_lvl_we) begin
                r_lvl[w_idx] <= n_lvl;
            end
            if (w_rp_we) begin
                r_rp[w_idx] <= n_rp;
            end
            r_status <= n_status;
            r_thr    <= n_thr;
            r_en     <= n_en;
            r_acc    <= n_acc;
            if (w_accept) begin
                r_ch <= '0;
            end else if (r_state == afb_pkg::ST_TICK || r_state == afb_pkg::ST_MIX) begin
                r_ch <= r_ch + 1'b1;
            end
        end
    end

    // item payload and accumulator
    always_ff @(posedge i_clk) begin
        r_rd <= n_rd;
        if (w_accept) begin
            r_kind   <= i_in.kind;
            r_offset <= i_in.offset;
            r_wdata  <= i_in.write_data;
            r_sum    <= '0;
        end else if (r_acc) begin
            r_sum <= r_sum + afb_pkg::SUM_W'(signed'(w_mem_q));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // samples are high bytes times 256, so the sum over 8 is exact: shift the byte sum by 5
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_rd  <= r_rd;
            r_out_irq <= (r_status != 8'd0);
            r_out_mix <= (r_kind == afb_pkg::KIND_FRAME)
                       ? {r_sum, {afb_pkg::MIX_SHIFT{1'b0}}} : '0;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_rd;
    assign o_out.irq       = r_out_irq;
    assign o_out.mix_left  = r_out_mix;
    assign o_out.mix_right = r_out_mix;

endmodule

@@ rtl/core/afb_checker.sv @@
// afb_checker: port-level checks on the audio fifo bank
// bound to audio_fifo_bank_with_threshold_irq; uses afb_pkg for widths
`timescale 1ns / 1ps

module afb_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [7:0]                       i_read_data,
    input logic                             i_irq,
    input logic signed [afb_pkg::MIX_W-1:0] i_mix_left,
    input logic signed [afb_pkg::MIX_W-1:0] i_mix_right
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_read_data) && $stable(i_irq) && $stable(i_mix_left))
        else $error("result payload changed while stalled");

    a_mix_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_mix_left == i_mix_right))
        else $error("left and right mix differ");

    // mixed value is a byte sum scaled by 32
    a_mix_grain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_mix_left[4:0] == 5'd0))
        else $error("mix value not a multiple of 32");

    // one item in flight: no beat taken straight after another
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while one is in work");

endmodule

bind audio_fifo_bank_with_threshold_irq afb_checker u_afb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_read_data (o_out.read_data),
    .i_irq       (o_out.irq),
    .i_mix_left  (o_out.mix_left),
    .i_mix_right (o_out.mix_right)
);
